FILE: rtl/prtt_pkg.sv
// Package: sizes, command and status codes for the priority ring task table.
package prtt_pkg;

    localparam int NUM_SLOTS  = 16;
    localparam int NUM_LEVELS = 8;

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int LVL_W  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;

    // 9-bit bounds so that the full 8-bit request fields compare cleanly
    localparam logic [8:0] SLOT_LIMIT  = 9'(NUM_SLOTS);
    localparam logic [8:0] LEVEL_LIMIT = 9'(NUM_LEVELS);

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_READ   = 2'd2,
        CMD_SET    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_PRIO = 2'd1,
        ST_FULL     = 2'd2,
        ST_BAD_SLOT = 2'd3
    } status_t;

endpackage

FILE: rtl/priority_ring_task_table.sv
// Top level: task slot pool with one circular doubly linked ring per priority level.
//
//  channel | direction | ports                                          | handshake
//  --------+-----------+------------------------------------------------+--------------------
//  s_      | in        | cmd, priority_req, target_slot, entry_address  | s_valid / s_ready
//  m_      | out       | status, new_slot, head_valid, head_slot        | m_valid / m_ready
//
// One request per cycle sustained while the output is not stalled. A request lands in
// the input register, is decoded against the slot and ring tables, and its answer is
// loaded into the output register at the same edge that updates the tables, so the
// next request sees the updated state.
// Reset (aresetn low, synchronous) frees every slot and empties every ring;
// links, levels, entries and heads are left as they are.
// A stalled output holds the input register; s_ready drops only when both
// registers are full and m_ready is low.
module priority_ring_task_table
    import prtt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [7:0]  s_priority_req,
    input  logic [7:0]  s_target_slot,
    input  logic [31:0] s_entry_address,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [3:0]  m_new_slot,
    output logic        m_head_valid,
    output logic [3:0]  m_head_slot
);

    // ---------------------------------------------------------------
    // Input register
    // ---------------------------------------------------------------
    logic        in_valid_reg, in_valid_next;
    cmd_t        in_cmd_reg;
    logic [7:0]  in_prio_reg;
    logic [7:0]  in_slot_reg;
    logic [31:0] in_entry_reg;

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    logic        m_valid_reg, m_valid_next;
    status_t     status_reg, status_next;
    logic [3:0]  new_slot_reg, new_slot_next;
    logic        head_valid_reg, head_valid_next;
    logic [3:0]  head_slot_reg, head_slot_next;

    // ---------------------------------------------------------------
    // Tables. Only slot_used and ring_valid have a reset value; the rest
    // is read only behind a set used or valid bit.
    // ---------------------------------------------------------------
    logic              slot_used_reg  [NUM_SLOTS];
    logic              slot_used_next [NUM_SLOTS];
    logic [SLOT_W-1:0] next_link_reg  [NUM_SLOTS];
    logic [SLOT_W-1:0] next_link_next [NUM_SLOTS];
    logic [SLOT_W-1:0] prev_link_reg  [NUM_SLOTS];
    logic [SLOT_W-1:0] prev_link_next [NUM_SLOTS];
    logic [LVL_W-1:0]  slot_level_reg [NUM_SLOTS];
    logic [LVL_W-1:0]  slot_level_next[NUM_SLOTS];
    logic [31:0]       slot_entry_reg [NUM_SLOTS];
    logic [31:0]       slot_entry_next[NUM_SLOTS];
    logic [SLOT_W-1:0] ring_head_reg  [NUM_LEVELS];
    logic [SLOT_W-1:0] ring_head_next [NUM_LEVELS];
    logic              ring_valid_reg [NUM_LEVELS];
    logic              ring_valid_next[NUM_LEVELS];

    // ---------------------------------------------------------------
    // Handshake
    // ---------------------------------------------------------------
    logic out_free;
    logic fire;

    assign out_free = !m_valid_reg || m_ready;
    assign fire     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    always_comb begin
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end

        if (fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // ---------------------------------------------------------------
    // Decode and table update
    // ---------------------------------------------------------------
    logic              prio_ok;
    logic              slot_ok;
    logic [LVL_W-1:0]  prio_idx;
    logic [SLOT_W-1:0] slot_idx;
    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
    logic [SLOT_W-1:0] head_idx;
    logic [SLOT_W-1:0] tail_idx;
    logic [SLOT_W-1:0] rm_next;
    logic [SLOT_W-1:0] rm_prev;
    logic [LVL_W-1:0]  rm_lvl;
    logic [7:0]        slot_wide;

    assign prio_ok  = {1'b0, in_prio_reg} < LEVEL_LIMIT;
    assign slot_ok  = {1'b0, in_slot_reg} < SLOT_LIMIT;
    assign prio_idx = in_prio_reg[LVL_W-1:0];
    assign slot_idx = in_slot_reg[SLOT_W-1:0];

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (!slot_used_reg[i]) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    assign head_idx = ring_head_reg[prio_idx];
    assign tail_idx = prev_link_reg[head_idx];
    assign rm_next  = next_link_reg[slot_idx];
    assign rm_prev  = prev_link_reg[slot_idx];
    assign rm_lvl   = slot_level_reg[slot_idx];

    always_comb begin
        slot_used_next  = slot_used_reg;
        next_link_next  = next_link_reg;
        prev_link_next  = prev_link_reg;
        slot_level_next = slot_level_reg;
        slot_entry_next = slot_entry_reg;
        ring_head_next  = ring_head_reg;
        ring_valid_next = ring_valid_reg;

        status_next     = ST_OK;
        slot_wide       = '0;
        head_valid_next = 1'b0;
        head_slot_next  = '0;

        case (in_cmd_reg)
            CMD_ADD: begin
                if (!prio_ok) begin
                    status_next = ST_BAD_PRIO;
                end else if (!free_found) begin
                    status_next = ST_FULL;
                end else begin
                    slot_used_next[free_idx]  = 1'b1;
                    slot_entry_next[free_idx] = in_entry_reg;
                    slot_level_next[free_idx] = prio_idx;
                    if (!ring_valid_reg[prio_idx]) begin
                        // first task of this level: one-element ring
                        ring_head_next[prio_idx]  = free_idx;
                        ring_valid_next[prio_idx] = 1'b1;
                        next_link_next[free_idx]  = free_idx;
                        prev_link_next[free_idx]  = free_idx;
                    end else begin
                        // insert between tail and head
                        prev_link_next[free_idx] = tail_idx;
                        next_link_next[free_idx] = head_idx;
                        next_link_next[tail_idx] = free_idx;
                        prev_link_next[head_idx] = free_idx;
                    end
                    slot_wide = 8'(free_idx);
                end
            end
            CMD_REMOVE: begin
                if (!slot_ok || !slot_used_reg[slot_idx]) begin
                    status_next = ST_BAD_SLOT;
                end else begin
                    if (rm_next == slot_idx) begin
                        ring_valid_next[rm_lvl] = 1'b0;
                    end else begin
                        next_link_next[rm_prev] = rm_next;
                        prev_link_next[rm_next] = rm_prev;
                        if (ring_valid_reg[rm_lvl] && ring_head_reg[rm_lvl] == slot_idx) begin
                            ring_head_next[rm_lvl] = rm_next;
                        end
                    end
                    slot_used_next[slot_idx] = 1'b0;
                end
            end
            CMD_READ: begin
                if (!prio_ok) begin
                    status_next = ST_BAD_PRIO;
                end else if (ring_valid_reg[prio_idx]) begin
                    head_valid_next = 1'b1;
                    head_slot_next  = 4'(8'(head_idx));
                end
            end
            CMD_SET: begin
                if (!prio_ok) begin
                    status_next = ST_BAD_PRIO;
                end else if (!slot_ok || !slot_used_reg[slot_idx]
                             || slot_level_reg[slot_idx] != prio_idx) begin
                    status_next = ST_BAD_SLOT;
                end else begin
                    ring_head_next[prio_idx]  = slot_idx;
                    ring_valid_next[prio_idx] = 1'b1;
                end
            end
            default: begin
                status_next = ST_OK;
            end
        endcase

        new_slot_next = slot_wide[3:0];
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                slot_used_reg[i] <= 1'b0;
            end
            for (int i = 0; i < NUM_LEVELS; i++) begin
                ring_valid_reg[i] <= 1'b0;
            end
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            if (fire) begin
                slot_used_reg  <= slot_used_next;
                ring_valid_reg <= ring_valid_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_cmd_reg   <= cmd_t'(s_cmd);
            in_prio_reg  <= s_priority_req;
            in_slot_reg  <= s_target_slot;
            in_entry_reg <= s_entry_address;
        end
        if (fire) begin
            status_reg      <= status_next;
            new_slot_reg    <= new_slot_next;
            head_valid_reg  <= head_valid_next;
            head_slot_reg   <= head_slot_next;
            next_link_reg   <= next_link_next;
            prev_link_reg   <= prev_link_next;
            slot_level_reg  <= slot_level_next;
            slot_entry_reg  <= slot_entry_next;
            ring_head_reg   <= ring_head_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = status_reg;
    assign m_new_slot   = new_slot_reg;
    assign m_head_valid = head_valid_reg;
    assign m_head_slot  = head_slot_reg;

endmodule
